/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the voice mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/wvm_pkg.sv */
// ----------------------------------------------------------------------------
// wvm_pkg
// Types, codes and constants of the wavetable voice mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package wvm_pkg;

  localparam int VOICES_DEF    = 24;
  localparam int SLOTS_DEF     = 24;
  localparam int SLOT_SIZE_DEF = 4096;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE    = 1'b1;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_RENDER = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_SLOT   = 3'd4;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_SUSTAIN = 2'd1;
  localparam logic [1:0] ST_RELEASE = 2'd2;

  localparam logic signed [7:0] SQ_AMP      = 8'sd48;
  localparam logic [8:0]        ENV_MAX     = 9'd256;
  localparam logic [8:0]        ENV_ATTACK  = 9'd8;
  localparam logic [8:0]        ENV_RELEASE = 9'd4;
  localparam logic [6:0]        PAN_MAX     = 7'd127;

  localparam int IDX_W = 16;  // integer part of the Q16.16 cursor
  localparam int LS_W  = 12;
  localparam int LEN_W = 13;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [4:0]        slot;
    logic [11:0]       address;
    logic [12:0]       slot_length;
    logic              looped;
    logic signed [7:0] sample_byte;
    logic              is_square;
    logic [29:0]       step;
    logic [15:0]       duty;
    logic [7:0]        length_ticks;
    logic [6:0]        volume;
    logic [6:0]        pan;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               voice_started;
    logic               any_voice_active;
  } res_t;

endpackage

`default_nettype wire

/* sv/wvm_ram.sv */
// ----------------------------------------------------------------------------
// wvm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* sv/wvm_rem.sv */
// ----------------------------------------------------------------------------
// wvm_rem
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wvm_pkg::IDX_W-1:0]   dividend,
  input  logic [wvm_pkg::LEN_W-1:0]   divisor,
  output logic                        done,
  output logic [wvm_pkg::LEN_W-1:0]   rem
);
  import wvm_pkg::*;

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   dvd;
  logic [LEN_W-1:0]   dsr;
  logic [LEN_W:0]     part;
  logic [LEN_W:0]     trial;

  // remainder stays below the divisor, so one extra bit holds the shifted trial
  assign trial = {part[LEN_W-1:0], dvd[IDX_W-1]};
  assign rem   = part[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(IDX_W);
        dvd     <= dividend;
        dsr     <= divisor;
        part    <= '0;
      end else if (running) begin
        if (trial >= {1'b0, dsr}) begin
          part <= trial - {1'b0, dsr};
        end else begin
          part <= trial;
        end
        dvd <= dvd << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/wavetable_voice_mixer.sv */
// ----------------------------------------------------------------------------
// wavetable_voice_mixer
// Voice pool mixer: square and sample voices mixed to a saturated stereo pair.
// ----------------------------------------------------------------------------
// One transaction is processed at a time; cmd_ready is high only while idle.
// Write, slot-info and tick commands pass through S_EXEC to S_DONE, as does a
// start that is dropped for an empty or out-of-range slot. A start scans the
// voice pool one voice per cycle, stopping at the first free voice. A render
// walks every voice one at a time through one shared 9x10 multiplier and the
// single sample memory port: a free voice or a voice that ends this frame is
// handled in S_VOICE alone; a square voice then runs the S_MUL steps for
// envelope, volume, left pan and right pan; a sample voice reads its byte in
// S_READ before S_MUL, and first waits in S_DIV on the bit-serial remainder
// unit when its cursor wraps into its loop.
// A result that is not taken holds the block in S_DONE until it is.
// Results sit in an output register, so a new command is accepted while the
// previous result waits. SLOT_SIZE must be a power of two. Sample memory
// content is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_voice_mixer #(
  parameter int VOICES    = wvm_pkg::VOICES_DEF,
  parameter int SLOTS     = wvm_pkg::SLOTS_DEF,
  parameter int SLOT_SIZE = wvm_pkg::SLOT_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  wvm_pkg::cmd_t                   cmd,
  output logic                            res_valid,
  input  logic                            res_ready,
  output wvm_pkg::res_t                   res,
  input  logic                            cfg_we,
  input  logic [wvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wvm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wvm_pkg::*;
`include "assert_macros.svh"

  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SLW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W    = $clog2(SLOT_SIZE);
  localparam int MEM_DEPTH = SLOTS * SLOT_SIZE;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(VOICES + 1);
  localparam int ACC_W     = 15 + $clog2(VOICES + 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_VOICE, S_DIV, S_READ, S_MUL, S_DONE
  } state_t;

  state_t state;
  cmd_t   item;

  logic              playing;
  logic              mute;
  logic [VW-1:0]     vidx;
  logic [1:0]        mstep;
  logic [CNT_W-1:0]  active_cnt;
  logic              started;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [7:0] smp;
  logic signed [7:0] e_reg;
  logic signed [7:0] val_reg;

  // voice pool
  logic [1:0]  v_status [VOICES];
  logic        v_square [VOICES];
  logic [4:0]  v_slot   [VOICES];
  logic [31:0] v_cursor [VOICES];
  logic [29:0] v_step   [VOICES];
  logic [15:0] v_duty   [VOICES];
  logic [7:0]  v_ticks  [VOICES];
  logic [8:0]  v_env    [VOICES];
  logic [6:0]  v_vol    [VOICES];
  logic [6:0]  v_pan    [VOICES];

  // slot info
  logic [LS_W-1:0]  si_ls     [SLOTS];
  logic [LEN_W-1:0] si_len    [SLOTS];
  logic             si_looped [SLOTS];

  // current voice view
  logic [1:0]  cur_status;
  logic [31:0] cur_cursor;
  logic [8:0]  cur_env;
  logic [4:0]  si_sel;
  logic        si_ok;
  logic [LS_W-1:0]  cur_ls;
  logic [LEN_W-1:0] cur_len;
  logic        cur_looped;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] wrap_idx;
  logic [IDX_W-1:0] rd_idx;
  logic        hit_end;
  logic        can_loop;
  logic [9:0]  att_sum;
  logic [8:0]  env_next;
  logic        rel_end;
  logic signed [7:0] sq_smp;
  logic [VOICES-1:0] busy_vec;
  logic              last_voice;

  // shared multiplier
  logic signed [8:0]  mul_a;
  logic signed [9:0]  mul_b;
  logic signed [18:0] prod;
  logic signed [18:0] shr;
  logic signed [7:0]  r8;
  logic signed [ACC_W-1:0] term;

  // memory and remainder unit
  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [7:0]        ram_q;
  logic              rem_start;
  logic              rem_done;
  logic [LEN_W-1:0]  rem_val;

  logic signed [15:0] left_sat;
  logic signed [15:0] right_sat;

  assign cmd_ready  = (state == S_IDLE);
  assign last_voice = (vidx == VW'(VOICES - 1));

  assign cur_status = v_status[vidx];
  assign cur_cursor = v_cursor[vidx];
  assign cur_env    = v_env[vidx];

  assign si_sel     = (state == S_EXEC) ? item.slot : v_slot[vidx];
  assign si_ok      = ({27'd0, si_sel} < 32'(SLOTS));
  assign cur_ls     = si_ls[SLW'(si_sel)];
  assign cur_len    = si_len[SLW'(si_sel)];
  assign cur_looped = si_looped[SLW'(si_sel)];

  assign cur_idx  = cur_cursor[31:16];
  assign hit_end  = (cur_idx >= {3'd0, cur_len});
  assign can_loop = cur_looped && (cur_len > {1'b0, cur_ls});
  assign wrap_idx = {4'd0, cur_ls} + {3'd0, rem_val};
  assign rd_idx   = (state == S_DIV) ? wrap_idx : cur_idx;

  assign att_sum  = {1'b0, cur_env} + {1'b0, ENV_ATTACK};
  assign rel_end  = (cur_env <= ENV_RELEASE);
  assign sq_smp   = (cur_cursor[15:0] < v_duty[vidx]) ? SQ_AMP : -SQ_AMP;

  always_comb begin
    if (cur_status == ST_SUSTAIN) begin
      if (cur_env >= ENV_MAX) begin
        env_next = cur_env;
      end else if (att_sum > {1'b0, ENV_MAX}) begin
        env_next = ENV_MAX;
      end else begin
        env_next = att_sum[8:0];
      end
    end else begin
      env_next = cur_env - ENV_RELEASE;
    end
  end

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      busy_vec[i] = (v_status[i] != ST_FREE);
    end
  end

  always_comb begin
    case (mstep)
      2'd0: begin
        mul_a = {smp[7], smp};
        mul_b = $signed({1'b0, v_env[vidx]});
      end
      2'd1: begin
        mul_a = {e_reg[7], e_reg};
        mul_b = $signed({3'd0, v_vol[vidx]});
      end
      2'd2: begin
        mul_a = {val_reg[7], val_reg};
        mul_b = $signed({3'd0, PAN_MAX - v_pan[vidx]});
      end
      default: begin
        mul_a = {val_reg[7], val_reg};
        mul_b = $signed({3'd0, v_pan[vidx]});
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign shr  = (mstep == 2'd0) ? (prod >>> 8) : (prod >>> 7);
  assign r8   = shr[7:0];
  assign term = {{(ACC_W - 14){r8[7]}}, r8, 6'd0};

  assign left_sat  = (acc_l > SAT_HI) ? 16'sh7FFF :
                     (acc_l < SAT_LO) ? 16'sh8000 : acc_l[15:0];
  assign right_sat = (acc_r > SAT_HI) ? 16'sh7FFF :
                     (acc_r < SAT_LO) ? 16'sh8000 : acc_r[15:0];

  assign ram_we = (state == S_EXEC) && (item.opcode == OP_WRITE) && si_ok &&
                  ({5'd0, item.address} < 17'(SLOT_SIZE));
  assign ram_addr = (state == S_EXEC) ?
                    MEM_AW'({item.slot, SLOT_W'(item.address)}) :
                    MEM_AW'({si_sel, SLOT_W'(rd_idx)});

  assign rem_start = (state == S_VOICE) && (cur_status != ST_FREE) &&
                     !(cur_status == ST_RELEASE && rel_end) &&
                     !v_square[vidx] && si_ok && hit_end && can_loop;

  wvm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item.sample_byte),
    .rdata (ram_q)
  );

  wvm_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (cur_idx - {4'd0, cur_ls}),
    .divisor  (cur_len - {1'b0, cur_ls}),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      playing    <= 1'b0;
      mute       <= 1'b0;
      active_cnt <= '0;
      for (int i = 0; i < VOICES; i++) begin
        v_status[i] <= ST_FREE;
      end
      for (int i = 0; i < SLOTS; i++) begin
        si_ls[i]     <= '0;
        si_len[i]    <= '0;
        si_looped[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLAYING: playing <= cfg_data[0];
          CFG_MUTE:    mute    <= cfg_data[0];
          default:     ;
        endcase
      end

      // S_DONE reloads the output register itself
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item  <= cmd;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          acc_l   <= '0;
          acc_r   <= '0;
          started <= 1'b0;
          vidx    <= '0;
          mstep   <= 2'd0;
          case (item.opcode)
            OP_START: begin
              if (item.is_square || (si_ok && cur_len != '0)) begin
                state <= S_SCAN;
              end else begin
                state <= S_DONE;
              end
            end
            OP_TICK: begin
              state <= S_DONE;
              for (int i = 0; i < VOICES; i++) begin
                if (v_status[i] == ST_SUSTAIN && v_ticks[i] != 8'd0) begin
                  v_ticks[i] <= v_ticks[i] - 8'd1;
                  if (v_ticks[i] == 8'd1) begin
                    v_status[i] <= ST_RELEASE;
                  end
                end
              end
            end
            OP_RENDER: begin
              if (playing && !mute) begin
                state <= S_VOICE;
              end else begin
                state <= S_DONE;
              end
            end
            OP_SLOT: begin
              state <= S_DONE;
              if (si_ok) begin
                si_ls[SLW'(item.slot)]     <= item.address;
                si_len[SLW'(item.slot)]    <=
                  ({4'd0, item.slot_length} > 17'(SLOT_SIZE)) ?
                  LEN_W'(SLOT_SIZE) : item.slot_length;
                si_looped[SLW'(item.slot)] <= item.looped;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        S_SCAN: begin
          if (cur_status == ST_FREE) begin
            v_status[vidx] <= ST_SUSTAIN;
            v_square[vidx] <= item.is_square;
            v_slot[vidx]   <= item.slot;
            v_cursor[vidx] <= '0;
            v_step[vidx]   <= (item.step == '0) ? 30'd1 : item.step;
            v_duty[vidx]   <= item.duty;
            v_ticks[vidx]  <= item.length_ticks;
            v_env[vidx]    <= '0;
            v_vol[vidx]    <= item.volume;
            v_pan[vidx]    <= item.pan;
            active_cnt     <= active_cnt + 1'b1;
            started        <= 1'b1;
            state          <= S_DONE;
          end else if (last_voice) begin
            state <= S_DONE;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end

        S_VOICE: begin
          if (cur_status == ST_FREE) begin
            if (last_voice) state <= S_DONE;
            else vidx <= vidx + 1'b1;
          end else if (cur_status == ST_RELEASE && rel_end) begin
            v_env[vidx]    <= '0;
            v_status[vidx] <= ST_FREE;
            active_cnt     <= active_cnt - 1'b1;
            if (last_voice) state <= S_DONE;
            else vidx <= vidx + 1'b1;
          end else begin
            v_env[vidx] <= env_next;
            if (v_square[vidx]) begin
              smp            <= sq_smp;
              v_cursor[vidx] <= cur_cursor + {2'd0, v_step[vidx]};
              state          <= S_MUL;
            end else if (si_ok && (!hit_end || can_loop)) begin
              // wrap waits on the remainder unit; a plain read goes straight out
              state <= hit_end ? S_DIV : S_READ;
            end else begin
              // drop a sample voice that ran off its end or has an out-of-range slot
              v_status[vidx] <= ST_FREE;
              active_cnt     <= active_cnt - 1'b1;
              if (last_voice) state <= S_DONE;
              else vidx <= vidx + 1'b1;
            end
          end
        end

        S_DIV: begin
          if (rem_done) begin
            v_cursor[vidx] <= {wrap_idx, cur_cursor[15:0]};
            state          <= S_READ;
          end
        end

        S_READ: begin
          smp            <= ram_q;
          v_cursor[vidx] <= cur_cursor + {2'd0, v_step[vidx]};
          state          <= S_MUL;
        end

        S_MUL: begin
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: e_reg   <= r8;
            2'd1: val_reg <= r8;
            2'd2: acc_l   <= acc_l + term;
            default: begin
              acc_r <= acc_r + term;
              if (last_voice) begin
                state <= S_DONE;
              end else begin
                vidx  <= vidx + 1'b1;
                state <= S_VOICE;
              end
            end
          endcase
        end

        S_DONE: begin
          // hold until the previous result is taken
          if (!res_valid || res_ready) begin
            res.left             <= left_sat;
            res.right            <= right_sat;
            res.voice_started    <= started;
            res.any_voice_active <= (active_cnt != '0);
            res_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `WVM_ASSERT_IMP(a_cnt_match, clk, rst, 1'b1, active_cnt == CNT_W'($countones(busy_vec)), "active count out of step with voice pool")
  `WVM_ASSERT_IMP(a_started_op, clk, rst, (state == S_DONE) && started, item.opcode == OP_START, "voice_started set for a non-start command")
  `WVM_ASSERT_NXT(a_rem_wait, clk, rst, rem_start, (state == S_DIV) && !rem_done, "remainder unit started outside loop wrap")

endmodule

`default_nettype wire
